// File: hw/rtl/cpsb_pkg.sv
// Shared types, register indexes and helpers for the clipped palette sprite blitter.
package cpsb_pkg;

  // Default sizing of the block.
  localparam int unsigned MAX_DIM_DEF      = 2048;
  localparam int unsigned PALETTE_SIZE_DEF = 256;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIC_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_PALETTE = 3'd6;

  // Command codes on the input channel.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Register file contents; dimensions are held already clamped.
  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [11:0] pic_width;
    logic [11:0] pic_height;
    logic [11:0] buffer_width;
    logic [11:0] buffer_height;
    logic        expand_palette;
  } cfg_t;

  // Contents of the pipeline register between the clip stage and the result stage.
  typedef struct packed {
    logic        valid;
    logic        visible;
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  index;
    logic        in_range;
    logic        done;
  } stage_t;

  // A zero dimension acts as one, and anything above the limit acts as the limit.
  function automatic logic [11:0] clamp_dim(input logic [11:0] v, input int unsigned max_dim);
    logic [12:0] lim;
    lim = 13'(max_dim);
    if (v == 12'd0) begin
      return 12'd1;
    end
    if ({1'b0, v} > lim) begin
      return lim[11:0];
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/cpsb_if.sv
// Valid/ready channel interfaces for source pixels and framebuffer writes.
interface cpsb_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  entry_index;
  logic [23:0] entry_color;
  logic [7:0]  pixel_value;

  modport source(output valid, output cmd, output entry_index, output entry_color,
                 output pixel_value, input ready);
  modport sink(input valid, input cmd, input entry_index, input entry_color,
               input pixel_value, output ready);
endinterface

interface cpsb_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [21:0] write_address;
  logic [23:0] write_data;
  logic        picture_done;

  modport source(output valid, output write_enable, output write_address,
                 output write_data, output picture_done, input ready);
  modport sink(input valid, input write_enable, input write_address,
               input write_data, input picture_done, output ready);
endinterface

// File: hw/rtl/cpsb_regs.sv
// Configuration register file with dimension clamping on write.
module cpsb_regs #(
  parameter int unsigned MAX_DIM = cpsb_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cpsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpsb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cpsb_pkg::cfg_t                   cfg
);
  import cpsb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_x         <= 12'd0;
      cfg.dest_y         <= 12'd0;
      cfg.pic_width      <= 12'd1;
      cfg.pic_height     <= 12'd1;
      cfg.buffer_width   <= clamp_dim(12'd320, MAX_DIM);
      cfg.buffer_height  <= clamp_dim(12'd240, MAX_DIM);
      cfg.expand_palette <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_X:         cfg.dest_x         <= cfg_data;
        CFG_DEST_Y:         cfg.dest_y         <= cfg_data;
        CFG_PIC_WIDTH:      cfg.pic_width      <= clamp_dim(cfg_data, MAX_DIM);
        CFG_PIC_HEIGHT:     cfg.pic_height     <= clamp_dim(cfg_data, MAX_DIM);
        CFG_BUFFER_WIDTH:   cfg.buffer_width   <= clamp_dim(cfg_data, MAX_DIM);
        CFG_BUFFER_HEIGHT:  cfg.buffer_height  <= clamp_dim(cfg_data, MAX_DIM);
        CFG_EXPAND_PALETTE: cfg.expand_palette <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The clamp must never leave a zero picture width behind a write.
  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_index == CFG_PIC_WIDTH |=> cfg.pic_width != 12'd0)
    else $error("picture width register holds zero after a write");
`endif

endmodule

// File: hw/rtl/cpsb_front.sv
// Source counters, clipping, palette memory and the first pipeline register.
module cpsb_front #(
  parameter int unsigned MAX_DIM      = cpsb_pkg::MAX_DIM_DEF,
  parameter int unsigned PALETTE_SIZE = cpsb_pkg::PALETTE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  cpsb_in_if.sink          sprite,
  input  cpsb_pkg::cfg_t   cfg,
  input  logic             take,
  output cpsb_pkg::stage_t stage,
  output logic [23:0]      color
);
  import cpsb_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned PAL_AW = $clog2(PALETTE_SIZE);
  localparam logic [8:0]  PAL_LIMIT = 9'(PALETTE_SIZE);

  logic [23:0]      palette [PALETTE_SIZE];
  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic [12:0]      col_inc;
  logic [12:0]      row_inc;
  logic             last_col;
  logic             last_row;
  logic [13:0]      px;
  logic [13:0]      py;
  logic             visible;
  logic             accept;
  logic             is_pixel;
  logic             s1_free;
  logic             pal_we;
  logic             pix_load;

  assign s1_free      = !stage.valid || take;
  assign sprite.ready = s1_free;
  assign accept       = sprite.valid && sprite.ready;
  assign is_pixel     = sprite.cmd == CMD_PIXEL;
  assign pix_load     = accept && is_pixel;
  assign pal_we       = accept && sprite.cmd == CMD_LOAD &&
                        ({1'b0, sprite.entry_index} < PAL_LIMIT);

  assign col_inc  = 13'(col) + 13'd1;
  assign row_inc  = 13'(row) + 13'd1;
  assign last_col = col_inc >= {1'b0, cfg.pic_width};
  assign last_row = row_inc >= {1'b0, cfg.pic_height};

  // Position in the buffer; bit 13 is the sign.
  assign px = {{2{cfg.dest_x[11]}}, cfg.dest_x} + 14'(col);
  assign py = {{2{cfg.dest_y[11]}}, cfg.dest_y} + 14'(row);
  assign visible = !px[13] && !py[13] &&
                   (px[12:0] < {1'b0, cfg.buffer_width}) &&
                   (py[12:0] < {1'b0, cfg.buffer_height});

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (pix_load) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : CNT_W'(row_inc);
      end else begin
        col <= CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (s1_free) begin
      stage.valid <= pix_load;
    end
    if (pix_load) begin
      stage.visible  <= visible;
      stage.px       <= px[11:0];
      stage.py       <= py[11:0];
      stage.index    <= sprite.pixel_value;
      stage.in_range <= {1'b0, sprite.pixel_value} < PAL_LIMIT;
      stage.done     <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette[sprite.entry_index[PAL_AW-1:0]] <= sprite.entry_color;
    end
    if (pix_load) begin
      color <= palette[sprite.pixel_value[PAL_AW-1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  // The final pixel of a picture sends both counters back to the origin.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    pix_load && last_col && last_row |=> col == '0 && row == '0)
    else $error("source counters did not wrap after the last pixel");

  // A stage waiting on the result register keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !take |=> stage.valid && $stable(stage) && (color === $past(color)))
    else $error("pipeline stage changed while stalled");
`endif

endmodule

// File: hw/rtl/cpsb_back.sv
// Address multiply, data selection and the result register.
module cpsb_back (
  input  logic             clk,
  input  logic             rst,
  input  cpsb_pkg::cfg_t   cfg,
  input  cpsb_pkg::stage_t stage,
  input  logic [23:0]      color,
  output logic             take,
  cpsb_out_if.source       frame
);
  import cpsb_pkg::*;

  logic [23:0] prod;
  logic [23:0] sum;
  logic [23:0] data_next;
  logic        load;

  assign take = !frame.valid || frame.ready;
  assign load = stage.valid && take;

  assign prod = 24'(stage.py) * 24'(cfg.buffer_width);
  assign sum  = prod + 24'(stage.px);

  always_comb begin
    if (!stage.visible) begin
      data_next = 24'd0;
    end else if (cfg.expand_palette) begin
      data_next = stage.in_range ? color : 24'd0;
    end else begin
      data_next = 24'(stage.index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (take) begin
      frame.valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame.write_enable  <= stage.visible;
      frame.write_address <= stage.visible ? sum[21:0] : 22'd0;
      frame.write_data    <= data_next;
      frame.picture_done  <= stage.done;
    end
  end

`ifndef NO_ASSERTIONS
  // A clipped pixel carries neither an address nor data.
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    frame.valid && !frame.write_enable |->
      frame.write_address == 22'd0 && frame.write_data == 24'd0)
    else $error("clipped pixel carries a non-zero address or data");
`endif

endmodule

// File: hw/rtl/clipped_palette_sprite_blit.sv
// Top level of the clipped palette sprite blitter.
// The block takes a picture of 8-bit palette indices in raster order on the sprite channel and
// turns every pixel transaction into one framebuffer write transaction on the frame channel,
// placing the picture's top-left corner at the signed position (dest_x, dest_y) and clipping it
// to the buffer on all four sides; a clipped pixel still produces a transaction, with
// write_enable low and address and data zero, and picture_done marks the picture's last pixel,
// after which the source counters start again at the first pixel. A load command writes one
// palette entry and produces no transaction. One transaction is accepted every clock cycle for
// as long as the frame side keeps taking results. A pixel passes through the two registers of
// the pipeline: the first captures the clipped position and the palette read at the accepting
// edge, the second the result after the address multiply once the result register is free,
// and the result register offers it on the frame channel. The palette is a single memory of
// PALETTE_SIZE entries, written by load commands and read once per pixel; it has no clearing
// pass, so a pixel must not refer to an entry that was never loaded in expanded mode.
// Configuration registers may be written only while no transaction is in flight.
module clipped_palette_sprite_blit #(
  parameter int unsigned MAX_DIM      = cpsb_pkg::MAX_DIM_DEF,
  parameter int unsigned PALETTE_SIZE = cpsb_pkg::PALETTE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  cpsb_in_if.sink                         sprite,
  cpsb_out_if.source                      frame,
  input  logic                            cfg_we,
  input  logic [cpsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpsb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cpsb_pkg::*;

  cfg_t        cfg;
  stage_t      stage;
  logic [23:0] color;
  logic        take;

  // Register file; dimensions are clamped as they are written.
  cpsb_regs #(
    .MAX_DIM(MAX_DIM)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Counters, clipping and palette: the first pipeline stage.
  cpsb_front #(
    .MAX_DIM     (MAX_DIM),
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .sprite(sprite),
    .cfg   (cfg),
    .take  (take),
    .stage (stage),
    .color (color)
  );

  // Address and data formation into the result register.
  cpsb_back u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .stage(stage),
    .color(color),
    .take (take),
    .frame(frame)
  );

endmodule

// File: dv/cpsb_frame_checker.sv
// Passive checker that predicts framebuffer write transactions and compares them as they leave.
`timescale 1ns / 100ps
module cpsb_frame_checker (
  input  logic                            clk,
  input  logic                            rst,
  cpsb_in_if                              sprite,
  cpsb_out_if                             frame,
  input  logic                            cfg_we,
  input  logic [cpsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpsb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              writes_owed
);
  import cpsb_pkg::*;

  localparam int DIM_LIMIT   = MAX_DIM_DEF;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic        write_enable;
    logic [21:0] write_address;
    logic [23:0] write_data;
    logic        picture_done;
  } fb_write_t;

  // Shadow copy of the register file and of the source counters.
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic [11:0]        pic_w;
  logic [11:0]        pic_h;
  logic [11:0]        buf_w;
  logic [11:0]        buf_h;
  logic               expand;
  logic [23:0]        colour_lut [PALETTE_SIZE_DEF];
  logic [10:0]        src_col;
  logic [10:0]        src_row;
  fb_write_t          pending_writes[$];

  // Printing stops after a while so that a badly broken block cannot flood the log.
  task automatic report_mismatch(input string field, input logic [23:0] seen,
                                 input logic [23:0] wanted);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t checker: %s got %h expected %h", $time, field, seen, wanted);
    end
    mismatches++;
  endtask

  // A zero size behaves as one, and anything above the limit as the limit.
  function automatic int eff_dim(input logic [11:0] v);
    if (v == 12'd0) begin
      return 1;
    end
    if (int'(v) > DIM_LIMIT) begin
      return DIM_LIMIT;
    end
    return int'(v);
  endfunction

  // Works out where the next source pixel lands and steps the raster counters.
  function automatic fb_write_t place_pixel(input logic [7:0] index);
    fb_write_t w;
    int        pw;
    int        ph;
    int        bw;
    int        bh;
    int        col_x;
    int        row_y;
    bit        end_col;
    bit        end_row;
    pw    = eff_dim(pic_w);
    ph    = eff_dim(pic_h);
    bw    = eff_dim(buf_w);
    bh    = eff_dim(buf_h);
    col_x = int'(pos_x) + int'(src_col);
    row_y = int'(pos_y) + int'(src_row);
    w     = '0;
    if (col_x >= 0 && row_y >= 0 && col_x < bw && row_y < bh) begin
      w.write_enable  = 1'b1;
      w.write_address = 22'(row_y * bw + col_x);
      w.write_data    = expand ? colour_lut[index] : {16'd0, index};
    end
    // A counter already at or past a shrunken size counts as the last of its row or picture.
    end_col        = (int'(src_col) + 1 >= pw);
    end_row        = (int'(src_row) + 1 >= ph);
    w.picture_done = end_col && end_row;
    if (end_col) begin
      src_col = '0;
      src_row = end_row ? 11'd0 : src_row + 11'd1;
    end else begin
      src_col = src_col + 11'd1;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    fb_write_t got;
    fb_write_t want;
    if (rst) begin
      mismatches = 0;
      pos_x   = '0;
      pos_y   = '0;
      pic_w   = 12'd1;
      pic_h   = 12'd1;
      buf_w   = 12'd320;
      buf_h   = 12'd240;
      expand  = 1'b1;
      src_col = '0;
      src_row = '0;
      pending_writes.delete();
    end else begin
      if (frame.valid && frame.ready) begin
        got = {frame.write_enable, frame.write_address, frame.write_data, frame.picture_done};
        if (pending_writes.size() == 0) begin
          report_mismatch("transaction with nothing expected", 24'(got), 24'd0);
        end else begin
          want = pending_writes.pop_front();
          if (got.write_enable !== want.write_enable) begin
            report_mismatch("write_enable", 24'(got.write_enable), 24'(want.write_enable));
          end
          if (got.write_address !== want.write_address) begin
            report_mismatch("write_address", 24'(got.write_address), 24'(want.write_address));
          end
          if (got.write_data !== want.write_data) begin
            report_mismatch("write_data", got.write_data, want.write_data);
          end
          if (got.picture_done !== want.picture_done) begin
            report_mismatch("picture_done", 24'(got.picture_done), 24'(want.picture_done));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEST_X:         pos_x  = cfg_data;
          CFG_DEST_Y:         pos_y  = cfg_data;
          CFG_PIC_WIDTH:      pic_w  = cfg_data;
          CFG_PIC_HEIGHT:     pic_h  = cfg_data;
          CFG_BUFFER_WIDTH:   buf_w  = cfg_data;
          CFG_BUFFER_HEIGHT:  buf_h  = cfg_data;
          CFG_EXPAND_PALETTE: expand = cfg_data[0];
          default: ;
        endcase
      end
      if (sprite.valid && sprite.ready) begin
        if (sprite.cmd == CMD_LOAD) begin
          colour_lut[sprite.entry_index] = sprite.entry_color;
        end else begin
          pending_writes.push_back(place_pixel(sprite.pixel_value));
        end
      end
    end
    writes_owed = pending_writes.size();
  end

endmodule

// File: dv/tb_top.sv
// Top of the blitter testbench: clock, reset, stimulus, frame-side back-pressure and verdict.
`timescale 1ns / 100ps
module tb_top;
  import cpsb_pkg::*;

  // Index 7 lies beyond the register list; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1700;
  // The pipeline is two stages deep; the extra drain also covers a load still in flight.
  localparam int DRAIN_CYCLES   = 4;
  // Slowest honest run: every transaction waiting out a long gap and a long stall, plus
  // the pauses between phases; this limit is several times that.
  localparam int CYCLE_LIMIT    = 1_000_000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    checker_errors;
  int                    writes_owed;
  int                    items_sent;
  int                    cycles;

  // When calm is set, neither side idles, so the block runs at full rate for a whole phase.
  bit                    calm;

  // What the stimulus knows of the current settings, used to aim the picture and to pick pixel indices.
  bit                    expand_on;
  int                    cur_pic_w;
  int                    cur_buf_w;
  int                    cur_pic_h;
  int                    cur_buf_h;

  // Palette entries that have been loaded. In expanded mode only these may be referenced,
  // since the palette has no defined contents before a load.
  bit                    loaded_mask [256];
  logic [7:0]            loaded_list [$];

  cpsb_in_if  sprite_bus ();
  cpsb_out_if frame_bus ();

  always #10 clk = ~clk;

  clipped_palette_sprite_blit u_dut (
    .clk       (clk),
    .rst       (rst),
    .sprite    (sprite_bus),
    .frame     (frame_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cpsb_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .sprite      (sprite_bus),
    .frame       (frame_bus),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (checker_errors),
    .writes_owed (writes_owed)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Sizes are mostly small so that pictures finish often; the rest hit the limit, the
  // values that must be clamped, or anything at all.
  function automatic logic [11:0] pick_dim(input int small_max);
    if ($urandom_range(0, 99) < 85) begin
      return 12'($urandom_range(1, small_max));
    end
    case ($urandom_range(0, 3))
      0:       return 12'd0;
      1:       return 12'd2048;
      2:       return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Positions mostly straddle the buffer so that every edge clips; some are extremes.
  function automatic logic [11:0] pick_pos(input int pic_span, input int buf_span);
    int v;
    case ($urandom_range(0, 9))
      0:       v = -2048;
      1:       v = 2047;
      2:       v = int'($urandom_range(0, 4095)) - 2048;
      default: v = int'($urandom_range(0, pic_span + buf_span + 4)) - (pic_span + 2);
    endcase
    if (v < -2048) begin
      v = -2048;
    end
    if (v > 2047) begin
      v = 2047;
    end
    return 12'(v);
  endfunction

  // Any index in raw mode; in expanded mode only an entry that has been loaded.
  function automatic logic [7:0] legal_pixel();
    if (expand_on) begin
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Register writes happen one per cycle, starting and ending on a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      CFG_PIC_WIDTH:      cur_pic_w = int'(value);
      CFG_PIC_HEIGHT:     cur_pic_h = int'(value);
      CFG_BUFFER_WIDTH:   cur_buf_w = int'(value);
      CFG_BUFFER_HEIGHT:  cur_buf_h = int'(value);
      CFG_EXPAND_PALETTE: expand_on = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Presents one transaction at a falling edge and holds it until the block takes it.
  // Returns on the falling edge after acceptance with valid still high, so a following
  // transaction can go back to back.
  task automatic send_txn(input logic cmd, input logic [7:0] idx, input logic [23:0] colour,
                          input logic [7:0] pix);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      sprite_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sprite_bus.valid       = 1'b1;
    sprite_bus.cmd         = cmd;
    sprite_bus.entry_index = idx;
    sprite_bus.entry_color = colour;
    sprite_bus.pixel_value = pix;
    @(posedge clk);
    while (!sprite_bus.ready) begin
      @(posedge clk);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // The fields a command does not use carry random values, which the block must ignore.
  task automatic send_pixel(input logic [7:0] pix);
    send_txn(CMD_PIXEL, 8'($urandom), 24'($urandom), pix);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [23:0] colour);
    send_txn(CMD_LOAD, idx, colour, 8'($urandom));
    if (!loaded_mask[idx]) begin
      loaded_mask[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  // Brings the block to rest: no transaction offered, every expected write returned, and
  // time for a trailing load to pass through, so that registers may be written safely.
  task automatic settle();
    sprite_bus.valid = 1'b0;
    while (writes_owed != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Frame side: ready drops for random stretches, except in calm phases.
  initial begin
    int stall_left;
    stall_left      = 0;
    frame_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && stall_left > 0) begin
        frame_bus.ready = 1'b0;
        stall_left--;
      end else begin
        frame_bus.ready = 1'b1;
        stall_left      = 0;
        if (!calm && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int phase_len;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    sprite_bus.valid       = 1'b0;
    sprite_bus.cmd         = CMD_LOAD;
    sprite_bus.entry_index = '0;
    sprite_bus.entry_color = '0;
    sprite_bus.pixel_value = '0;
    calm                   = 1'b0;
    items_sent             = 0;
    expand_on              = 1'b1;
    cur_pic_w              = 1;
    cur_pic_h              = 1;
    cur_buf_w              = 320;
    cur_buf_h              = 240;
    foreach (loaded_mask[i]) begin
      loaded_mask[i] = 1'b0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Reset settings: a one-pixel picture at the origin in expanded mode. The palette is
    // filled first with the extreme indices and colours, then each pixel is a whole picture.
    load_entry(8'h00, 24'h000000);
    load_entry(8'hFF, 24'hFFFFFF);
    load_entry(8'hA5, 24'h5A5A5A);
    load_entry(8'h5A, 24'hA5A5A5);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hA5);

    // A 3x3 picture one pixel up and left of a 1x1 buffer: only its centre lands, the rest
    // is clipped on every side. Raw index mode.
    settle();
    write_reg(CFG_EXPAND_PALETTE, 12'd0);
    write_reg(CFG_PIC_WIDTH, 12'd3);
    write_reg(CFG_PIC_HEIGHT, 12'd3);
    write_reg(CFG_DEST_X, 12'hFFF);
    write_reg(CFG_DEST_Y, 12'hFFF);
    write_reg(CFG_BUFFER_WIDTH, 12'd1);
    write_reg(CFG_BUFFER_HEIGHT, 12'd1);
    for (int k = 0; k < 9; k++) begin
      send_pixel(k == 0 ? 8'h00 : (k == 1 ? 8'hFF : 8'($urandom)));
    end

    // Sizes out of range (zero and the largest code) and the extreme positions, plus a
    // write to the index past the register list.
    settle();
    write_reg(CFG_PIC_WIDTH, 12'd0);
    write_reg(CFG_PIC_HEIGHT, 12'd4095);
    write_reg(CFG_BUFFER_WIDTH, 12'd0);
    write_reg(CFG_BUFFER_HEIGHT, 12'd4095);
    write_reg(CFG_DEST_X, 12'h7FF);
    write_reg(CFG_DEST_Y, 12'h800);
    write_reg(CFG_EXPAND_PALETTE, 12'd1);
    write_reg(CFG_UNUSED, 12'($urandom));
    repeat (3) send_pixel(legal_pixel());

    // A full-width picture started, then the width shrunk below the column already reached:
    // the next pixel must end its row and the counter must wrap.
    settle();
    write_reg(CFG_PIC_WIDTH, 12'd2048);
    write_reg(CFG_PIC_HEIGHT, 12'd2);
    write_reg(CFG_DEST_X, 12'd0);
    write_reg(CFG_DEST_Y, 12'd0);
    write_reg(CFG_BUFFER_WIDTH, 12'd2048);
    write_reg(CFG_BUFFER_HEIGHT, 12'd2048);
    repeat (4) send_pixel(legal_pixel());
    settle();
    write_reg(CFG_PIC_WIDTH, 12'd2);
    repeat (2) send_pixel(legal_pixel());

    // Random phases. Each one may change any subset of the registers while the block is at
    // rest, then streams pixels with the odd palette load mixed in. Phases often stop in the
    // middle of a picture, so a later size change lands on a picture in progress.
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) < 6) begin
          write_reg(CFG_PIC_WIDTH, pick_dim(8));
        end
        if ($urandom_range(0, 9) < 6) begin
          write_reg(CFG_PIC_HEIGHT, pick_dim(6));
        end
        if ($urandom_range(0, 9) < 6) begin
          write_reg(CFG_BUFFER_WIDTH, pick_dim(24));
        end
        if ($urandom_range(0, 9) < 6) begin
          write_reg(CFG_BUFFER_HEIGHT, pick_dim(24));
        end
        if ($urandom_range(0, 9) < 7) begin
          write_reg(CFG_DEST_X, pick_pos(cur_pic_w, cur_buf_w));
        end
        if ($urandom_range(0, 9) < 7) begin
          write_reg(CFG_DEST_Y, pick_pos(cur_pic_h, cur_buf_h));
        end
        if ($urandom_range(0, 9) < 4) begin
          write_reg(CFG_EXPAND_PALETTE, 12'($urandom_range(0, 1)));
        end
      end
      phase_len = $urandom_range(4, 40);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < 12) begin
          load_entry(8'($urandom_range(0, 255)), 24'($urandom));
        end else begin
          send_pixel(legal_pixel());
        end
      end
    end

    calm = 1'b0;
    settle();
    if (checker_errors == 0 && writes_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cpsb_pkg.sv
hw/rtl/cpsb_if.sv
hw/rtl/cpsb_regs.sv
hw/rtl/cpsb_front.sv
hw/rtl/cpsb_back.sv
hw/rtl/clipped_palette_sprite_blit.sv
dv/cpsb_frame_checker.sv
dv/tb_top.sv
